// ===== design/hrhp_pkg.sv =====
// Shared types, codes and character-class functions of the request head parser.
package hrhp_pkg;

  localparam logic [2:0] EV_BYTE    = 3'd0;
  localparam logic [2:0] EV_END     = 3'd1;
  localparam logic [2:0] EV_VERSION = 3'd2;
  localparam logic [2:0] EV_HEADEND = 3'd3;
  localparam logic [2:0] EV_ERROR   = 3'd4;

  localparam logic [2:0] K_METHOD = 3'd0;
  localparam logic [2:0] K_PATH   = 3'd1;
  localparam logic [2:0] K_QUERY  = 3'd2;
  localparam logic [2:0] K_NAME   = 3'd3;
  localparam logic [2:0] K_VALUE  = 3'd4;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [23:0] {
    PH_METHOD0    = 24'h000001,
    PH_METHOD     = 24'h000002,
    PH_URL0       = 24'h000004,
    PH_URL        = 24'h000008,
    PH_URLESC     = 24'h000010,
    PH_QUERY      = 24'h000020,
    PH_PROTO0     = 24'h000040,
    PH_PROTO      = 24'h000080,
    PH_VER0       = 24'h000100,
    PH_VERMAJ     = 24'h000200,
    PH_VERMAJE    = 24'h000400,
    PH_VERMIN     = 24'h000800,
    PH_LINEEND    = 24'h001000,
    PH_H0         = 24'h002000,
    PH_HCR        = 24'h004000,
    PH_HNAME      = 24'h008000,
    PH_HNAMESP    = 24'h010000,
    PH_HBODY0     = 24'h020000,
    PH_HBODY      = 24'h040000,
    PH_HBODY_CR   = 24'h080000,
    PH_HBODY_CRLF = 24'h100000,
    PH_HEND_CR    = 24'h200000,
    PH_DONE       = 24'h400000,
    PH_ERROR      = 24'h800000
  } phase_t;

  typedef struct packed {
    logic [2:0] ev;
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t mk_res(logic [2:0] ev, logic [2:0] kind, logic [7:0] data);
    res_t r;
    r.ev   = ev;
    r.kind = kind;
    r.data = data;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_method_char(logic [7:0] c);
    logic r;
    case (c)
      8'h22, 8'h28, 8'h29, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D,
      8'h3E, 8'h3F, 8'h40, 8'h5B, 8'h5C, 8'h5D, 8'h7B, 8'h7D: r = 1'b1;
      default: r = is_letter(c);
    endcase
    return r;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == 8'h20 || c == 8'h09;
  endfunction

  function automatic logic is_visible(logic [7:0] c);
    return c > 8'd32 && c < 8'd127;
  endfunction

  // 16 flags a byte that is no hex digit
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] r;
    if (c >= "0" && c <= "9") r = {1'b0, c[3:0]};
    else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) r = {1'b0, c[3:0]} + 5'd9;
    else r = 5'd16;
    return r;
  endfunction

  function automatic logic [7:0] proto_char(logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = "H";
      2'd1:    r = "T";
      2'd2:    r = "T";
      default: r = "P";
    endcase
    return r;
  endfunction

  // returns {mismatch, count}
  function automatic logic [3:0] proto_upd(logic [2:0] cnt, logic mm, logic [7:0] c);
    logic [7:0] u;
    logic [3:0] r;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    if (!mm && cnt < 3'd4 && u == proto_char(cnt[1:0])) r = {1'b0, cnt + 3'd1};
    else r = {1'b1, cnt};
    return r;
  endfunction

endpackage

// ===== design/hrhp_fsm.sv =====
// Parse state registers and per-byte next-state and result logic.
module hrhp_fsm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  logic [7:0]      byte_c,
  output hrhp_pkg::push_t push
);
  import hrhp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] hn_r, hn_nxt;
  logic       esc_r, esc_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       mm_r, mm_nxt;

  logic       err;
  logic [1:0] n;
  res_t       r0, r1;
  logic [4:0] hv;
  logic [3:0] pu;

  always_comb begin
    phase_nxt = phase_r;
    hn_nxt    = hn_r;
    esc_nxt   = esc_r;
    cnt_nxt   = cnt_r;
    mm_nxt    = mm_r;
    err       = 1'b0;
    n         = 2'd0;
    r0        = '0;
    r1        = '0;
    hv        = hex_value(byte_c);
    pu        = proto_upd(cnt_r, mm_r, byte_c);
    case (phase_r)
      PH_METHOD0: begin
        if (is_method_char(byte_c)) begin
          r0 = mk_res(EV_BYTE, K_METHOD, byte_c); n = 2'd1; phase_nxt = PH_METHOD;
        end else if (!is_blank(byte_c)) err = 1'b1;
      end
      PH_METHOD: begin
        if (is_method_char(byte_c)) begin
          r0 = mk_res(EV_BYTE, K_METHOD, byte_c); n = 2'd1;
        end else if (byte_c == " ") begin
          r0 = mk_res(EV_END, K_METHOD, 8'd0); n = 2'd1; phase_nxt = PH_URL0;
        end else err = 1'b1;
      end
      PH_URL0: begin
        if (!is_blank(byte_c)) begin
          if (byte_c > 8'd32 && byte_c < 8'd128) begin
            r0 = mk_res(EV_BYTE, K_PATH, byte_c); n = 2'd1; phase_nxt = PH_URL;
          end else err = 1'b1;
        end
      end
      PH_URL: begin
        if (byte_c == "?") begin
          r0 = mk_res(EV_END, K_PATH, 8'd0); n = 2'd1; phase_nxt = PH_QUERY;
        end else if (is_blank(byte_c)) begin
          r0 = mk_res(EV_END, K_PATH, 8'd0); n = 2'd1; phase_nxt = PH_PROTO0;
        end else if (byte_c == "+") begin
          r0 = mk_res(EV_BYTE, K_PATH, " "); n = 2'd1;
        end else if (byte_c == "%") begin
          esc_nxt = 1'b0; hn_nxt = 4'd0; phase_nxt = PH_URLESC;
        end else if (byte_c > 8'd32 && byte_c < 8'd128) begin
          r0 = mk_res(EV_BYTE, K_PATH, byte_c); n = 2'd1;
        end else err = 1'b1;
      end
      PH_URLESC: begin
        if (hv[4]) err = 1'b1;
        else if (!esc_r) begin
          hn_nxt = hv[3:0]; esc_nxt = 1'b1;
        end else begin
          r0 = mk_res(EV_BYTE, K_PATH, {hn_r, hv[3:0]}); n = 2'd1;
          esc_nxt = 1'b0; hn_nxt = 4'd0; phase_nxt = PH_URL;
        end
      end
      PH_QUERY: begin
        if (is_blank(byte_c)) begin
          r0 = mk_res(EV_END, K_QUERY, 8'd0); n = 2'd1; phase_nxt = PH_PROTO0;
        end else begin
          r0 = mk_res(EV_BYTE, K_QUERY, byte_c); n = 2'd1;
        end
      end
      PH_PROTO0: begin
        if (!is_blank(byte_c)) begin
          if (is_letter(byte_c)) begin
            pu = proto_upd(3'd0, 1'b0, byte_c);
            cnt_nxt = pu[2:0]; mm_nxt = pu[3]; phase_nxt = PH_PROTO;
          end else err = 1'b1;
        end
      end
      PH_PROTO: begin
        if (is_blank(byte_c) || byte_c == "/") begin
          if (mm_r || cnt_r != 3'd4) err = 1'b1;
          else phase_nxt = (byte_c == "/") ? PH_VERMAJ : PH_VER0;
        end else if (is_letter(byte_c)) begin
          cnt_nxt = pu[2:0]; mm_nxt = pu[3];
        end else err = 1'b1;
      end
      PH_VER0: begin
        if (!is_blank(byte_c)) begin
          if (byte_c == "/") phase_nxt = PH_VERMAJ;
          else err = 1'b1;
        end
      end
      PH_VERMAJ: begin
        if (!is_blank(byte_c)) begin
          if (byte_c == "1") phase_nxt = PH_VERMAJE;
          else err = 1'b1;
        end
      end
      PH_VERMAJE: begin
        if (!is_blank(byte_c)) begin
          if (byte_c == ".") phase_nxt = PH_VERMIN;
          else err = 1'b1;
        end
      end
      PH_VERMIN: begin
        if (!is_blank(byte_c)) begin
          if (byte_c == "0" || byte_c == "1") begin
            r0 = mk_res(EV_VERSION, K_METHOD, byte_c - 8'd48); n = 2'd1;
            phase_nxt = PH_LINEEND;
          end else err = 1'b1;
        end
      end
      PH_LINEEND: begin
        if (byte_c == 8'h0A) phase_nxt = PH_H0;
        else if (!(is_blank(byte_c) || byte_c == 8'h0D)) err = 1'b1;
      end
      PH_H0: begin
        if (!is_blank(byte_c)) begin
          if (is_visible(byte_c)) begin
            r0 = mk_res(EV_BYTE, K_NAME, byte_c); n = 2'd1; phase_nxt = PH_HNAME;
          end else if (byte_c == 8'h0D) phase_nxt = PH_HCR;
          else if (byte_c == 8'h0A) begin
            r0 = mk_res(EV_HEADEND, K_METHOD, 8'd0); n = 2'd1; phase_nxt = PH_DONE;
          end else err = 1'b1;
        end
      end
      PH_HCR, PH_HEND_CR: begin
        if (byte_c == 8'h0A) begin
          r0 = mk_res(EV_HEADEND, K_METHOD, 8'd0); n = 2'd1; phase_nxt = PH_DONE;
        end else err = 1'b1;
      end
      PH_HNAME: begin
        if (byte_c == ":") begin
          r0 = mk_res(EV_END, K_NAME, 8'd0); n = 2'd1; phase_nxt = PH_HBODY0;
        end else if (is_blank(byte_c)) begin
          r0 = mk_res(EV_END, K_NAME, 8'd0); n = 2'd1; phase_nxt = PH_HNAMESP;
        end else if (is_visible(byte_c)) begin
          r0 = mk_res(EV_BYTE, K_NAME, byte_c); n = 2'd1;
        end else err = 1'b1;
      end
      PH_HNAMESP: begin
        if (byte_c == ":") phase_nxt = PH_HBODY0;
        else if (!is_blank(byte_c)) err = 1'b1;
      end
      PH_HBODY0: begin
        if (byte_c == 8'h0D) phase_nxt = PH_HBODY_CR;
        else if (byte_c == 8'h0A) phase_nxt = PH_HBODY_CRLF;
        else if (!(byte_c == " " || (byte_c >= 8'd9 && byte_c <= 8'd13))) begin
          r0 = mk_res(EV_BYTE, K_VALUE, byte_c); n = 2'd1; phase_nxt = PH_HBODY;
        end
      end
      PH_HBODY: begin
        if (byte_c == 8'h0D) phase_nxt = PH_HBODY_CR;
        else if (byte_c == 8'h0A) phase_nxt = PH_HBODY_CRLF;
        else begin
          r0 = mk_res(EV_BYTE, K_VALUE, byte_c); n = 2'd1;
        end
      end
      PH_HBODY_CR: begin
        if (byte_c == 8'h0A) phase_nxt = PH_HBODY_CRLF;
        else err = 1'b1;
      end
      PH_HBODY_CRLF: begin
        if (byte_c == 8'h0D) begin
          r0 = mk_res(EV_END, K_VALUE, 8'd0); n = 2'd1; phase_nxt = PH_HEND_CR;
        end else if (byte_c == 8'h0A) begin
          r0 = mk_res(EV_END, K_VALUE, 8'd0);
          r1 = mk_res(EV_HEADEND, K_METHOD, 8'd0);
          n = 2'd2; phase_nxt = PH_DONE;
        end else if (is_blank(byte_c)) begin
          r0 = mk_res(EV_BYTE, K_VALUE, byte_c); n = 2'd1; phase_nxt = PH_HBODY;
        end else if (is_visible(byte_c)) begin
          r0 = mk_res(EV_END, K_VALUE, 8'd0);
          r1 = mk_res(EV_BYTE, K_NAME, byte_c);
          n = 2'd2; phase_nxt = PH_HNAME;
        end else err = 1'b1;
      end
      default: begin
      end
    endcase

    if (err) begin
      r0 = mk_res(EV_ERROR, K_METHOD, byte_c);
      n = 2'd1;
      phase_nxt = PH_ERROR;
    end
    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;

    push.n  = advance ? n : 2'd0;
    push.r0 = r0;
    push.r1 = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_METHOD0;
      hn_r    <= 4'd0;
      esc_r   <= 1'b0;
      cnt_r   <= 3'd0;
      mm_r    <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      hn_r    <= hn_nxt;
      esc_r   <= esc_nxt;
      cnt_r   <= cnt_nxt;
      mm_r    <= mm_nxt;
    end
  end

endmodule

// ===== design/hrhp_outq.sv =====
// Result queue: takes up to two results a cycle, hands out one while out_stall is low.
module hrhp_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  hrhp_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_stall,
  output hrhp_pkg::res_t  head
);
  import hrhp_pkg::*;

  res_t             mem [QDEPTH];
  logic [QAW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt, wr1;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = cnt_r != '0;
  assign head      = mem[rd_r];
  assign pop       = out_valid && !out_stall;
  assign room      = cnt_r <= (QAW+1)'(QDEPTH - 2);
  assign wr1       = wr_r + QAW'(1);
  assign wr_nxt    = wr_r + QAW'(push.n);
  assign rd_nxt    = pop ? rd_r + QAW'(1) : rd_r;
  assign cnt_nxt   = cnt_r + (QAW+1)'(push.n) - (QAW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr_r] <= push.r0;
    if (push.n == 2'd2) mem[wr1] <= push.r1;
  end

endmodule

// ===== design/http_request_head_parser.sv =====
// Top level of the HTTP request head parser.
//
// Input channel: one request byte per item on in_byte_in, taken when in_valid
// is high and in_stall low. Result channel: one result per item on out_*,
// taken when out_valid is high and out_stall low. A byte gives zero, one or
// two results; out_last_of_run marks the final one of a byte.
// The input stage register holds an accepted byte until the queue has room; the
// byte is then parsed and its results are written into the result queue,
// from whose head the first one shows on out_valid.
// Throughput: one byte per cycle while each byte gives at most one result and
// out_stall stays low; the result port moves one result a cycle, so bytes that
// give two results back up in the queue. The input stage holds one byte and a
// four-entry result queue decouples the sides; in_stall rises while a byte
// waits and the queue has fewer than two free entries.
// Reset (rst_n low at a clock edge) returns the parser to the start of a
// method and empties the queue. When the receiver stalls, the head result
// holds steady and bytes keep flowing until the queue has fewer than two free entries.
// After head end or an error the block gives no more results until reset.
module http_request_head_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_event_code,
  output logic [2:0] out_field_kind,
  output logic [7:0] out_data_byte,
  output logic       out_last_of_run
);
  import hrhp_pkg::*;

  logic       stage_v_r, stage_v_nxt;
  logic [7:0] byte_r;
  logic       room, advance, accept;
  push_t      push;
  res_t       head;

  assign advance     = stage_v_r && room;
  assign in_stall    = stage_v_r && !room;
  assign accept      = in_valid && !in_stall;
  assign stage_v_nxt = accept ? 1'b1 : (advance ? 1'b0 : stage_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) stage_v_r <= 1'b0;
    else stage_v_r <= stage_v_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) byte_r <= in_byte_in;
  end

  hrhp_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .byte_c  (byte_r),
    .push    (push)
  );

  hrhp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_event_code  = head.ev;
  assign out_field_kind  = head.kind;
  assign out_data_byte   = head.data;
  assign out_last_of_run = head.last;

endmodule

// ===== design/hrhp_checker.sv =====
// Port-level checks of the request head parser, bound to the top level.
module hrhp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_event_code,
  input logic [2:0] out_field_kind,
  input logic [7:0] out_data_byte,
  input logic       out_last_of_run
);
  import hrhp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_code)
      && $stable(out_field_kind) && $stable(out_data_byte) && $stable(out_last_of_run))
    else $error("result changed while stalled");

  a_kind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_code == EV_VERSION || out_event_code == EV_HEADEND
      || out_event_code == EV_ERROR) |-> out_field_kind == K_METHOD)
    else $error("field kind set on a non-field result");

  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_code == EV_HEADEND || out_event_code == EV_ERROR)
      |-> out_last_of_run)
    else $error("head end or error not last of its byte");

  a_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall
      && (out_event_code == EV_HEADEND || out_event_code == EV_ERROR) |=> !out_valid)
    else $error("result after head end or error");

endmodule

bind http_request_head_parser hrhp_checker u_hrhp_checker (.*);

// ===== sim/http_request_head_parser_test.sv =====
// Self-checking testbench for the HTTP request head parser: one request head of random headers.
module http_request_head_parser_test;
  import hrhp_pkg::*;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [7:0] TAB = 8'h09;
  localparam logic [7:0] LF = 8'h0A;
  localparam logic [7:0] CR = 8'h0D;
  localparam logic [31:0] PROTO_WORD = "HTTP";
  localparam logic [31:0] VALUE_LEAD = {8'h20, 8'h09, 8'h0B, 8'h0C};
  localparam int RANDOM_ITEMS = 2000;
  localparam int HOLD_AT = 200;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_AT = 1000;
  localparam int SETTLE_LIMIT = 10000;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    int         n;
    res_t       r;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte_in = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_event_code;
  logic [2:0] out_field_kind;
  logic [7:0] out_data_byte;
  logic       out_last_of_run;

  phase_t     prs_phase = PH_METHOD0;
  logic [3:0] esc_hi = 4'd0;
  logic       esc_held = 1'b0;
  logic [2:0] proto_cnt = 3'd0;
  logic       proto_bad = 1'b0;

  res_t       step_out[2];
  int         step_n;
  res_t       head_results[$];
  res_t       oldest;
  row_t       dir_rows[$];
  logic [7:0] line_buf[$];
  int         bytes_sent = 0;
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;
  logic       hold_off = 1'b0;
  bit         failed = 1'b0;

  http_request_head_parser dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_in      (in_byte_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_code  (out_event_code),
    .out_field_kind  (out_field_kind),
    .out_data_byte   (out_data_byte),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 200000);
    $display("http_request_head_parser verification failed");
    $finish;
  end

  function automatic logic alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic token_char(logic [7:0] c);
    case (c)
      "\"", "(", ")", ",", "/", ":", ";", "<", "=", ">", "?", "@", "[", "\\", "]", "{", "}":
        return 1'b1;
      default:
        return alpha(c);
    endcase
  endfunction

  function automatic logic blank(logic [7:0] c);
    return c == " " || c == TAB;
  endfunction

  function automatic logic graphic(logic [7:0] c);
    return c >= 8'd33 && c <= 8'd126;
  endfunction

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hexval(logic [7:0] c);
    logic [7:0] d;
    d = 8'h10;
    if (c >= "0" && c <= "9") d = c - "0";
    if (c >= "a" && c <= "f") d = c - "a" + 8'd10;
    if (c >= "A" && c <= "F") d = c - "A" + 8'd10;
    return d[4:0];
  endfunction

  function automatic logic [7:0] value_byte();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    if (v == CR || v == LF) v = "v";
    return v;
  endfunction

  function automatic void emit(logic [2:0] ev, logic [2:0] kind, logic [7:0] data);
    step_out[step_n].ev = ev;
    step_out[step_n].kind = kind;
    step_out[step_n].data = data;
    step_out[step_n].last = 1'b0;
    step_n++;
  endfunction

  function automatic void match_proto(logic [7:0] c);
    logic [7:0] up;
    up = (c >= "a" && c <= "z") ? (c & 8'hDF) : c;
    if (!proto_bad && proto_cnt < 3'd4 && up == PROTO_WORD[8 * (3 - int'(proto_cnt)) +: 8])
      proto_cnt++;
    else
      proto_bad = 1'b1;
  endfunction

  task automatic parse_byte(input logic [7:0] c);
    logic       err;
    logic [4:0] hv;
    err = 1'b0;
    step_n = 0;
    case (prs_phase)
      PH_METHOD0: begin
        if (token_char(c)) begin
          emit(EV_BYTE, K_METHOD, c);
          prs_phase = PH_METHOD;
        end else if (!blank(c)) err = 1'b1;
      end
      PH_METHOD: begin
        if (token_char(c)) emit(EV_BYTE, K_METHOD, c);
        else if (c == " ") begin
          emit(EV_END, K_METHOD, 8'h00);
          prs_phase = PH_URL0;
        end else err = 1'b1;
      end
      PH_URL0: begin
        if (!blank(c)) begin
          if (c > 8'd32 && c < 8'd128) begin
            emit(EV_BYTE, K_PATH, c);
            prs_phase = PH_URL;
          end else err = 1'b1;
        end
      end
      PH_URL: begin
        if (c == "?") begin
          emit(EV_END, K_PATH, 8'h00);
          prs_phase = PH_QUERY;
        end else if (blank(c)) begin
          emit(EV_END, K_PATH, 8'h00);
          prs_phase = PH_PROTO0;
        end else if (c == "+") emit(EV_BYTE, K_PATH, " ");
        else if (c == "%") begin
          esc_held = 1'b0;
          esc_hi = 4'd0;
          prs_phase = PH_URLESC;
        end else if (c > 8'd32 && c < 8'd128) emit(EV_BYTE, K_PATH, c);
        else err = 1'b1;
      end
      PH_URLESC: begin
        hv = hexval(c);
        if (hv[4]) err = 1'b1;
        else if (!esc_held) begin
          esc_hi = hv[3:0];
          esc_held = 1'b1;
        end else begin
          emit(EV_BYTE, K_PATH, {esc_hi, hv[3:0]});
          esc_held = 1'b0;
          esc_hi = 4'd0;
          prs_phase = PH_URL;
        end
      end
      PH_QUERY: begin
        if (blank(c)) begin
          emit(EV_END, K_QUERY, 8'h00);
          prs_phase = PH_PROTO0;
        end else emit(EV_BYTE, K_QUERY, c);
      end
      PH_PROTO0: begin
        if (!blank(c)) begin
          if (alpha(c)) begin
            proto_cnt = 3'd0;
            proto_bad = 1'b0;
            match_proto(c);
            prs_phase = PH_PROTO;
          end else err = 1'b1;
        end
      end
      PH_PROTO: begin
        if (blank(c) || c == "/") begin
          if (proto_bad || proto_cnt != 3'd4) err = 1'b1;
          else prs_phase = (c == "/") ? PH_VERMAJ : PH_VER0;
        end else if (alpha(c)) match_proto(c);
        else err = 1'b1;
      end
      PH_VER0: begin
        if (!blank(c)) begin
          if (c == "/") prs_phase = PH_VERMAJ;
          else err = 1'b1;
        end
      end
      PH_VERMAJ: begin
        if (!blank(c)) begin
          if (c == "1") prs_phase = PH_VERMAJE;
          else err = 1'b1;
        end
      end
      PH_VERMAJE: begin
        if (!blank(c)) begin
          if (c == ".") prs_phase = PH_VERMIN;
          else err = 1'b1;
        end
      end
      PH_VERMIN: begin
        if (!blank(c)) begin
          if (c == "0" || c == "1") begin
            emit(EV_VERSION, KIND_NONE, {7'd0, c[0]});
            prs_phase = PH_LINEEND;
          end else err = 1'b1;
        end
      end
      PH_LINEEND: begin
        if (c == LF) prs_phase = PH_H0;
        else if (!(blank(c) || c == CR)) err = 1'b1;
      end
      PH_H0: begin
        if (!blank(c)) begin
          if (graphic(c)) begin
            emit(EV_BYTE, K_NAME, c);
            prs_phase = PH_HNAME;
          end else if (c == CR) prs_phase = PH_HCR;
          else if (c == LF) begin
            emit(EV_HEADEND, KIND_NONE, 8'h00);
            prs_phase = PH_DONE;
          end else err = 1'b1;
        end
      end
      PH_HCR, PH_HEND_CR: begin
        if (c == LF) begin
          emit(EV_HEADEND, KIND_NONE, 8'h00);
          prs_phase = PH_DONE;
        end else err = 1'b1;
      end
      PH_HNAME: begin
        if (c == ":") begin
          emit(EV_END, K_NAME, 8'h00);
          prs_phase = PH_HBODY0;
        end else if (blank(c)) begin
          emit(EV_END, K_NAME, 8'h00);
          prs_phase = PH_HNAMESP;
        end else if (graphic(c)) emit(EV_BYTE, K_NAME, c);
        else err = 1'b1;
      end
      PH_HNAMESP: begin
        if (c == ":") prs_phase = PH_HBODY0;
        else if (!blank(c)) err = 1'b1;
      end
      PH_HBODY0: begin
        if (c == CR) prs_phase = PH_HBODY_CR;
        else if (c == LF) prs_phase = PH_HBODY_CRLF;
        else if (!(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
          emit(EV_BYTE, K_VALUE, c);
          prs_phase = PH_HBODY;
        end
      end
      PH_HBODY: begin
        if (c == CR) prs_phase = PH_HBODY_CR;
        else if (c == LF) prs_phase = PH_HBODY_CRLF;
        else emit(EV_BYTE, K_VALUE, c);
      end
      PH_HBODY_CR: begin
        if (c == LF) prs_phase = PH_HBODY_CRLF;
        else err = 1'b1;
      end
      PH_HBODY_CRLF: begin
        if (c == CR) begin
          emit(EV_END, K_VALUE, 8'h00);
          prs_phase = PH_HEND_CR;
        end else if (c == LF) begin
          emit(EV_END, K_VALUE, 8'h00);
          emit(EV_HEADEND, KIND_NONE, 8'h00);
          prs_phase = PH_DONE;
        end else if (blank(c)) begin
          emit(EV_BYTE, K_VALUE, c);
          prs_phase = PH_HBODY;
        end else if (graphic(c)) begin
          emit(EV_END, K_VALUE, 8'h00);
          emit(EV_BYTE, K_NAME, c);
          prs_phase = PH_HNAME;
        end else err = 1'b1;
      end
      default: ;
    endcase
    if (err) begin
      emit(EV_ERROR, KIND_NONE, c);
      prs_phase = PH_ERROR;
    end
    if (step_n > 0) step_out[step_n - 1].last = 1'b1;
  endtask

  task automatic typed_row(input logic [7:0] b, input int n, input logic [2:0] ev,
                           input logic [2:0] kind, input logic [7:0] data);
    row_t row;
    row.b = b;
    row.typed = 1'b1;
    row.n = n;
    row.r.ev = ev;
    row.r.kind = kind;
    row.r.data = data;
    row.r.last = 1'b0;
    dir_rows.push_back(row);
  endtask

  task automatic pred_row(input logic [7:0] b);
    row_t row;
    row.b = b;
    row.typed = 1'b0;
    row.n = 0;
    row.r = '0;
    dir_rows.push_back(row);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed, input int n_typed,
                           input res_t r_typed);
    res_t r;
    if (bytes_sent < 500) begin
      src_idle_pct = 0;
      sink_stall_pct = 0;
    end else if (bytes_sent < 1000) begin
      src_idle_pct = 53;
      sink_stall_pct = 0;
    end else if (bytes_sent < 1500) begin
      src_idle_pct = 0;
      sink_stall_pct = 53;
    end else begin
      src_idle_pct = 13;
      sink_stall_pct = 13;
    end
    // sender pause: let every pending result drain
    if (bytes_sent == DRAIN_AT) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (head_results.size() != 0) @(posedge clk);
    end
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_in <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    parse_byte(b);
    if (typed) begin
      if (n_typed > 0) begin
        r = r_typed;
        r.last = 1'b1;
        head_results.push_back(r);
      end
    end else begin
      for (int i = 0; i < step_n; i++) head_results.push_back(step_out[i]);
    end
  endtask

  // long receiver hold-off while the sender keeps offering
  initial begin
    @(posedge clk);
    while (bytes_sent < HOLD_AT) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (head_results.size() == 0) begin
        $error("unexpected result: event_code %0d field_kind %0d data_byte %0d",
               out_event_code, out_field_kind, out_data_byte);
        failed = 1'b1;
      end else begin
        oldest = head_results.pop_front();
        if (out_event_code !== oldest.ev) begin
          $error("event_code expected %0d got %0d", oldest.ev, out_event_code);
          failed = 1'b1;
        end
        if (out_field_kind !== oldest.kind) begin
          $error("field_kind expected %0d got %0d", oldest.kind, out_field_kind);
          failed = 1'b1;
        end
        if (out_data_byte !== oldest.data) begin
          $error("data_byte expected %0d got %0d", oldest.data, out_data_byte);
          failed = 1'b1;
        end
        if (out_last_of_run !== oldest.last) begin
          $error("last_of_run expected %0d got %0d", oldest.last, out_last_of_run);
          failed = 1'b1;
        end
      end
    end
    out_stall <= hold_off || ($urandom_range(0, 99) < sink_stall_pct);
  end

  initial begin
    logic [7:0] b;
    int         len;
    bit         first_line;
    int         wait_cycles;
    first_line = 1'b1;

    // request line: blanks, method, path with decoding, query, protocol, version
    typed_row(TAB, 0, EV_BYTE, KIND_NONE, 8'h00);
    typed_row(" ", 0, EV_BYTE, KIND_NONE, 8'h00);
    typed_row("g", 1, EV_BYTE, K_METHOD, "g");
    typed_row("}", 1, EV_BYTE, K_METHOD, "}");
    typed_row(" ", 1, EV_END, K_METHOD, 8'h00);
    typed_row("+", 1, EV_BYTE, K_PATH, "+");
    typed_row("+", 1, EV_BYTE, K_PATH, " ");
    typed_row("%", 0, EV_BYTE, KIND_NONE, 8'h00);
    typed_row("F", 0, EV_BYTE, KIND_NONE, 8'h00);
    typed_row("f", 1, EV_BYTE, K_PATH, 8'hFF);
    pred_row("%");
    pred_row("0");
    pred_row("a");
    typed_row("?", 1, EV_END, K_PATH, 8'h00);
    typed_row(8'hFF, 1, EV_BYTE, K_QUERY, 8'hFF);
    typed_row(8'h00, 1, EV_BYTE, K_QUERY, 8'h00);
    typed_row(TAB, 1, EV_END, K_QUERY, 8'h00);
    pred_row("h");
    pred_row("T");
    pred_row("t");
    pred_row("P");
    pred_row("/");
    pred_row("1");
    pred_row(".");
    typed_row("1", 1, EV_VERSION, KIND_NONE, 8'd1);
    pred_row(CR);
    pred_row(LF);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].n, dir_rows[i].r);

    // header lines: names, optional blanks before colon, leading blanks, folds
    while (bytes_sent < RANDOM_ITEMS) begin
      line_buf.delete();
      if (first_line && $urandom_range(0, 1)) line_buf.push_back(" ");
      first_line = 1'b0;
      len = $urandom_range(1, 6);
      repeat (len) begin
        b = 8'($urandom_range(33, 126));
        if (b == ":") b = "-";
        line_buf.push_back(b);
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) line_buf.push_back($urandom_range(0, 1) ? " " : TAB);
      line_buf.push_back(":");
      if ($urandom_range(0, 2) == 0) line_buf.push_back(VALUE_LEAD[8 * $urandom_range(0, 3) +: 8]);
      len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 10);
      repeat (len) line_buf.push_back(value_byte());
      if ($urandom_range(0, 1)) line_buf.push_back(CR);
      line_buf.push_back(LF);
      if ($urandom_range(0, 4) == 0) begin
        line_buf.push_back($urandom_range(0, 1) ? " " : TAB);
        repeat ($urandom_range(0, 6)) line_buf.push_back(value_byte());
        if ($urandom_range(0, 1)) line_buf.push_back(CR);
        line_buf.push_back(LF);
      end
      foreach (line_buf[i]) send_byte(line_buf[i], 1'b0, 0, '0);
    end

    // close the head, break it, or throw noise at it; then bytes that must stay silent
    line_buf.delete();
    case ($urandom_range(0, 3))
      0: begin
        line_buf.push_back(CR);
        line_buf.push_back(LF);
      end
      1: line_buf.push_back(LF);
      2: begin
        case ($urandom_range(0, 2))
          0: line_buf.push_back(8'($urandom_range(0, 8)));
          1: line_buf.push_back(8'($urandom_range(127, 255)));
          default: begin
            line_buf.push_back("X");
            line_buf.push_back(CR);
          end
        endcase
      end
      default: repeat (24) line_buf.push_back(8'($urandom_range(0, 255)));
    endcase
    repeat (16) line_buf.push_back(8'($urandom_range(0, 255)));
    foreach (line_buf[i]) send_byte(line_buf[i], 1'b0, 0, '0);
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (head_results.size() != 0 && wait_cycles < SETTLE_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (head_results.size() != 0) begin
      $error("%0d results never arrived", head_results.size());
      failed = 1'b1;
    end
    if (!failed)
      $display("http_request_head_parser verification clean");
    else
      $display("http_request_head_parser verification failed");
    $finish;
  end

endmodule
